// ===== rtl/tem_pkg.sv =====
// Shared constants and the Q30 sine series for the tremolo envelope modulator.
// Depends on nothing; imported by tem_sine_rom, tremolo_envelope_modulator and the testbench.
package tem_pkg;

  // Envelope and sine values are Q1.16, unity is 1 << 16
  localparam int ENV_BITS = 17;
  localparam logic [ENV_BITS-1:0] ENV_UNITY = 17'h1_0000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Config register indexes
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_DEPTH      = 1'b1;

  // sin(x) for x in [0, pi/2], Q30 in and out; eight-term Taylor series
  function automatic logic signed [63:0] tem_sine_q30(input logic [63:0] x);
    logic [63:0]        t;
    logic signed [63:0] sum;
    t   = x;
    sum = signed'(x);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd6;    sum = sum - signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd20;   sum = sum + signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd42;   sum = sum - signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd72;   sum = sum + signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd110;  sum = sum - signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd156;  sum = sum + signed'(t);
    t = (t * x) >> 30;  t = ((t * x) >> 30) / 64'd210;  sum = sum - signed'(t);
    return sum;
  endfunction

endpackage

// ===== rtl/tremolo_envelope_modulator.sv =====
// Top level of the tremolo envelope modulator: config registers, sequencer, datapath.
// Depends on tem_pkg, tem_mul and tem_sine_rom.
//
//  port group   direction  handshake                      payload
//  in_*         input      in_valid / in_stall            in_sample, in_frame_start
//  out_*        output     out_valid / out_stall          out_scaled_sample, out_frame_start_out
//  APB          in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A beat with frame start set steps through accept, phase add, index multiply,
// table read, envelope multiply, envelope clamp, sample multiply, output load;
// other beats skip to sample multiply. The one shared multiplier sets these steps.
// in_stall is high whenever the sequencer is busy; a finished beat waits in the
// output register while the next one is accepted and worked on.
// Reset (rst_n low, synchronous) clears phase, envelope to unity, both registers.
module tremolo_envelope_modulator
  import tem_pkg::*;
#(
  parameter int SAMPLE_BITS      = 24,
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_scaled_sample,
  output logic                          out_frame_start_out,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int Q_BITS   = PHASE_BITS - 1;
  localparam int MA_TMP   = (Q_BITS > SAMPLE_BITS) ? Q_BITS : SAMPLE_BITS;
  localparam int MA_BITS  = (MA_TMP > 16) ? MA_TMP : 16;
  localparam int MP_BITS  = MA_BITS + ENV_BITS;
  localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [MP_BITS:0]  IDX_HALF  = (MP_BITS+1)'(1) << (PHASE_BITS - 3);
  localparam logic [MP_BITS:0]  IDX_MAX_W = (MP_BITS+1)'(SINE_TABLE_DEPTH);
  localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(SINE_TABLE_DEPTH);
  localparam logic [Q_BITS-1:0] QUARTER   = Q_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [32:0]       NUM_ONE   = 33'h0_8000_0000;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PHASE   = 3'd1;
  localparam logic [2:0] ST_IDX     = 3'd2;
  localparam logic [2:0] ST_ROM     = 3'd3;
  localparam logic [2:0] ST_ENV_MUL = 3'd4;
  localparam logic [2:0] ST_ENV     = 3'd5;
  localparam logic [2:0] ST_SMP_MUL = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [31:0]                  phase_step_r;
  logic [15:0]                  depth_r;
  logic [PHASE_BITS-1:0]        phase_r, phase_nxt;
  logic [ENV_BITS-1:0]          envelope_r, envelope_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                         fs_r;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                         out_fs_r;

  logic                         accept;
  logic                         cfg_wr;
  logic                         out_load;
  logic                         mul_en;
  logic [MA_BITS-1:0]           mul_a;
  logic [ENV_BITS-1:0]          mul_b;
  logic [MP_BITS-1:0]           prod_r;
  logic [Q_BITS-1:0]            q_raw, q_fold;
  logic [MP_BITS:0]             idx_sum, idx_shift;
  logic [IDX_BITS-1:0]          rom_addr;
  logic                         rom_en;
  logic [ENV_BITS-1:0]          sine_r;
  logic [32:0]                  env_diff;
  logic                         neg;
  logic [SAMPLE_BITS-1:0]       mag;
  logic [SAMPLE_BITS-1:0]       scaled_mag;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // config registers and readback
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      depth_r      <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PHASE_STEP: phase_step_r <= pwdata;
        REG_DEPTH:      depth_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PHASE_STEP: prdata = phase_step_r;
      REG_DEPTH:      prdata = {16'h0000, depth_r};
      default:        prdata = '0;
    endcase
  end

  // phase fold onto a quarter wave of |sin|
  assign q_raw  = phase_r[Q_BITS-1:0];
  assign q_fold = (q_raw > QUARTER) ? (Q_BITS'(0) - q_raw) : q_raw;

  // rounded table index from q * depth of table
  assign idx_sum   = {1'b0, prod_r} + IDX_HALF;
  assign idx_shift = idx_sum >> (PHASE_BITS - 2);
  assign rom_addr  = (idx_shift > IDX_MAX_W) ? IDX_MAX : idx_shift[IDX_BITS-1:0];
  assign rom_en    = (state_r == ST_ROM);

  // envelope: 2^31 - depth*(1 - s), clamped at zero, back to Q16
  assign env_diff = NUM_ONE - prod_r[32:0];

  // sign and magnitude of the sample
  assign neg        = sample_r[SAMPLE_BITS-1];
  assign mag        = neg ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(sample_r)) : SAMPLE_BITS'(sample_r);
  assign scaled_mag = prod_r[16 +: SAMPLE_BITS];

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_IDX: begin
        mul_en = 1'b1;
        mul_a  = MA_BITS'(q_fold);
        mul_b  = ENV_BITS'(SINE_TABLE_DEPTH);
      end
      ST_ENV_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA_BITS'(depth_r);
        mul_b  = ENV_UNITY - sine_r;
      end
      ST_SMP_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA_BITS'(mag);
        mul_b  = envelope_r;
      end
      default: ;
    endcase
  end

  tem_mul #(
    .A_BITS (MA_BITS),
    .B_BITS (ENV_BITS)
  ) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  tem_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk    (clk),
    .en     (rom_en),
    .addr   (rom_addr),
    .data_r (sine_r)
  );

  // sequencer
  assign out_load = (state_r == ST_OUT) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = in_frame_start ? ST_PHASE : ST_SMP_MUL;
      ST_PHASE:   state_nxt = ST_IDX;
      ST_IDX:     state_nxt = ST_ROM;
      ST_ROM:     state_nxt = ST_ENV_MUL;
      ST_ENV_MUL: state_nxt = ST_ENV;
      ST_ENV:     state_nxt = ST_SMP_MUL;
      ST_SMP_MUL: state_nxt = ST_OUT;
      ST_OUT:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // phase, envelope and output valid next values
  always_comb begin
    phase_nxt    = phase_r;
    envelope_nxt = envelope_r;
    if (state_r == ST_PHASE) begin
      phase_nxt = phase_r + PHASE_BITS'(phase_step_r);
    end
    if (state_r == ST_ENV) begin
      envelope_nxt = (prod_r[32:0] > NUM_ONE) ? '0 : env_diff[31:15];
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      envelope_r  <= ENV_UNITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      envelope_r  <= envelope_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input capture and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      fs_r     <= in_frame_start;
    end
    if (out_load) begin
      out_sample_r <= neg ? signed'(SAMPLE_BITS'(0) - scaled_mag) : signed'(scaled_mag);
      out_fs_r     <= fs_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_scaled_sample   = out_sample_r;
  assign out_frame_start_out = out_fs_r;

  // checks
  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    envelope_r <= ENV_UNITY)
    else $error("envelope above unity");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("output valid raised outside the output step");

  a_phase_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(phase_r)) |-> $past(state_r) == ST_PHASE)
    else $error("phase changed outside the phase step");

  a_env_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(envelope_r)) |-> $past(state_r) == ST_ENV)
    else $error("envelope changed outside the envelope step");

endmodule

// ===== rtl/tem_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Standalone; used by tremolo_envelope_modulator for index, envelope and sample.
module tem_mul #(
  parameter int A_BITS = 31,
  parameter int B_BITS = 17
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] prod_r
);

  // one product per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
    end
  end

endmodule

// ===== rtl/tem_sine_rom.sv =====
// Quarter-wave |sin| table in Q1.16, DEPTH+1 entries, registered read.
// Depends on tem_pkg for the Q30 series and scaling constants.
module tem_sine_rom
  import tem_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [$clog2(DEPTH+1)-1:0] addr,
  output logic [ENV_BITS-1:0]        data_r
);

  // entry k = sin(pi/2 * k/DEPTH), rounded half up to Q16, capped at unity
  function automatic logic [ENV_BITS-1:0] rom_entry(input int unsigned k);
    logic [63:0]        x;
    logic signed [63:0] s;
    logic signed [63:0] r;
    x = (HALF_PI_Q30 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
    s = tem_sine_q30(x);
    if (s < 0) begin
      s = 0;
    end
    r = (s + 64'sd8192) >>> 14;
    if (r > 64'sd65536) begin
      r = 64'sd65536;
    end
    return r[ENV_BITS-1:0];
  endfunction

  logic [ENV_BITS-1:0] rom_w [0:DEPTH];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam logic [ENV_BITS-1:0] ENTRY = rom_entry(k);
    assign rom_w[k] = ENTRY;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom_w[addr];
    end
  end

endmodule

// ===== test/tb_tremolo_envelope_modulator.sv =====
// Self-checking testbench for tremolo_envelope_modulator: APB register setup, beat
// driver and monitor, and an in-bench tremolo predictor. Depends on tem_pkg and the RTL.
module tb_tremolo_envelope_modulator;
  import tem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 24;
  localparam int LUT_DEPTH = 256;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 frame_start;
  } pcm_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] scaled;
    logic                 frame_start;
  } tremolo_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_sample = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SW-1:0] out_scaled_sample;
  logic out_frame_start_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor state and register shadows
  int          sine_lut [0:LUT_DEPTH];
  logic [31:0] lfo_phase = '0;
  int          gain_env = 65536;
  logic [31:0] step_reg = '0;
  logic [15:0] depth_reg = '0;

  pcm_beat_t    pending_beats [$];
  tremolo_out_t expected_scaled [$];
  int           mismatches = 0;
  bit           in_taken = 1'b0;
  int           in_gap_left = 0;
  bit           in_calm = 1'b0;
  int           stall_left = 0;
  bit           out_calm = 1'b0;

  tremolo_envelope_modulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_frame_start      (in_frame_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scaled_sample   (out_scaled_sample),
    .out_frame_start_out (out_frame_start_out),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #6 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #5ms;
    $display("FAIL tremolo_envelope_modulator");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Q30 Taylor series for sin over [0, pi/2]
  function automatic longint sine_series_q30(input longint unsigned x);
    longint unsigned term;
    longint unsigned div;
    longint acc;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      div = longint'(2 * n * (2 * n + 1));
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / div;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  // Quarter-wave sine, Q1.16, rounded half up and capped at unity
  task automatic build_sine_lut();
    longint unsigned x;
    longint s;
    longint r;
    for (int k = 0; k <= LUT_DEPTH; k++) begin
      x = (QUARTER_TURN_Q30 * longint'(k) + LUT_DEPTH / 2) / LUT_DEPTH;
      s = sine_series_q30(x);
      if (s < 0) s = 0;
      r = (s + 8192) >>> 14;
      if (r > 65536) r = 65536;
      sine_lut[k] = int'(r);
    end
  endtask

  // Advance the LFO on a frame start, then scale the sample by the held envelope
  function automatic tremolo_out_t apply_tremolo(input pcm_beat_t b);
    longint unsigned q;
    longint unsigned idx;
    longint num;
    longint mag;
    longint prod;
    int s;
    tremolo_out_t r;
    if (b.frame_start) begin
      lfo_phase = lfo_phase + step_reg;
      q = {33'b0, lfo_phase[30:0]};
      if (q > 64'h4000_0000) q = 64'h8000_0000 - q;
      idx = (q * LUT_DEPTH + 64'h2000_0000) >> 30;
      if (idx > LUT_DEPTH) idx = LUT_DEPTH;
      s = sine_lut[idx];
      num = (longint'(1) <<< 31) - longint'(depth_reg) * 65536 + longint'(depth_reg) * s;
      gain_env = (num < 0) ? 0 : int'(num >>> 15);
    end
    mag = (b.sample < 0) ? -longint'(b.sample) : longint'(b.sample);
    prod = (mag * gain_env) >>> 16;
    if (b.sample < 0) prod = -prod;
    r.scaled = prod[SW-1:0];
    r.frame_start = b.frame_start;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // APB write followed by a read-back of the same register
  task automatic write_reg(input logic idx, input logic [31:0] val);
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PHASE_STEP) step_reg = val;
    else depth_reg = val[15:0];
    want = (idx == REG_PHASE_STEP) ? step_reg : {16'b0, depth_reg};
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      flag_mismatch($sformatf("reg %0d read-back: expected %h got %h", idx, want, prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_beat(input logic signed [SW-1:0] smp, input logic fs);
    pcm_beat_t b;
    b.sample = smp;
    b.frame_start = fs;
    pending_beats.push_back(b);
  endtask

  // Interleaved frames of random channel count, with some stray frame flags
  task automatic queue_frames(input int count);
    int chans;
    logic signed [SW-1:0] smp;
    logic fs;
    chans = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      fs = ((i % chans) == 0);
      if ($urandom_range(0, 11) == 0) fs = $urandom_range(0, 1);
      case ($urandom_range(0, 11))
        0: begin
          smp = 24'sh800000;
        end
        1: begin
          smp = 24'sh7FFFFF;
        end
        2: begin
          smp = '0;
        end
        3: begin
          smp = -24'sd1;
        end
        default: begin
          smp = SW'($urandom());
        end
      endcase
      queue_beat(smp, fs);
    end
  endtask

  // Sender holds off until every expected beat is back and the block is quiet
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_scaled.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    pcm_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled beat
    end else if (in_gap_left > 0) begin
      in_valid <= 1'b0;
      in_gap_left--;
    end else if (pending_beats.size() != 0) begin
      b = pending_beats.pop_front();
      in_valid <= 1'b1;
      in_sample <= b.sample;
      in_frame_start <= b.frame_start;
      if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
      if (!in_calm && $urandom_range(0, 2) == 0) in_gap_left = gap_len();
      else in_gap_left = 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (!out_calm && $urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  // Monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    tremolo_out_t want;
    pcm_beat_t b;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        b.sample = in_sample;
        b.frame_start = in_frame_start;
        expected_scaled.push_back(apply_tremolo(b));
      end
      if (out_valid && !out_stall) begin
        if (expected_scaled.size() == 0) begin
          flag_mismatch($sformatf("unexpected output beat: scaled %0d frame_start %b",
                                  out_scaled_sample, out_frame_start_out));
        end else begin
          want = expected_scaled.pop_front();
          if (out_scaled_sample !== want.scaled)
            flag_mismatch($sformatf("scaled_sample: expected %0d got %0d",
                                    want.scaled, out_scaled_sample));
          if (out_frame_start_out !== want.frame_start)
            flag_mismatch($sformatf("frame_start_out: expected %b got %b",
                                    want.frame_start, out_frame_start_out));
        end
      end
    end
  end

  initial begin
    logic [31:0] step_val;
    logic [15:0] depth_val;
    build_sine_lut();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No frame start yet: unity gain whatever depth says
    write_reg(REG_DEPTH, 32'h0000_FFFF);
    write_reg(REG_PHASE_STEP, 32'h0);
    queue_beat(24'sh800000, 1'b0);
    queue_beat(24'sh7FFFFF, 1'b0);
    queue_beat(24'sd0, 1'b0);
    queue_beat(-24'sd1, 1'b0);
    queue_beat(24'sd1, 1'b0);
    // Depth near two at a sine null drives the envelope negative, clamped to zero
    queue_beat(24'sh7FFFFF, 1'b1);
    queue_beat(24'sh800000, 1'b0);
    drain();

    // Quarter-turn steps alternate the sine peak and null at full depth
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_DEPTH, 32'h0000_8000);
    queue_beat(24'sh7FFFFF, 1'b1);
    queue_beat(24'sh800000, 1'b0);
    queue_beat(24'sh123456, 1'b1);
    queue_beat(-24'sd77, 1'b0);
    queue_beat(24'sh800000, 1'b1);
    queue_beat(-24'sd1, 1'b1);
    drain();

    // Largest step with zero depth: exact unity
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH, 32'h0);
    queue_beat(24'sh800000, 1'b1);
    queue_beat(24'sh7FFFFF, 1'b0);
    queue_beat(-24'sd3, 1'b1);
    queue_beat(24'sh555555, 1'b0);
    queue_beat(24'shAAAAAA, 1'b1);
    drain();

    // Random settings, each followed by a stretch of frames
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: begin
          step_val = 32'h0;
        end
        1: begin
          step_val = 32'hFFFF_FFFF;
        end
        2: begin
          step_val = $urandom_range(1, 1 << 20);
        end
        3: begin
          step_val = 32'h8000_0000;
        end
        default: begin
          step_val = $urandom();
        end
      endcase
      case ($urandom_range(0, 4))
        0: begin
          depth_val = 16'h0;
        end
        1: begin
          depth_val = 16'hFFFF;
        end
        2: begin
          depth_val = 16'h8000;
        end
        default: begin
          depth_val = 16'($urandom());
        end
      endcase
      write_reg(REG_PHASE_STEP, step_val);
      write_reg(REG_DEPTH, {16'b0, depth_val});
      queue_frames(68);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_scaled.size() == 0) begin
      $display("PASS tremolo_envelope_modulator");
    end else begin
      $display("FAIL tremolo_envelope_modulator");
    end
    $finish;
  end

endmodule
